[design/mpct_pkg.sv]
package mpct_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int CURSOR_W       = 12;
    localparam int SIZE_W         = 13;
    localparam int BUTTON_W       = 3;
    localparam int STATUS_W       = 3;

    localparam logic [7:0] HDR_SYNC     = 8'h08;
    localparam logic [7:0] HDR_OVERFLOW = 8'hC0;
    localparam logic [7:0] HDR_XSIGN    = 8'h10;
    localparam logic [7:0] HDR_YSIGN    = 8'h20;
    localparam logic [7:0] HDR_BUTTONS  = 8'h07;

    localparam logic [SIZE_W-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [SIZE_W-1:0] HEIGHT_RESET = 13'd480;

    localparam logic CMD_DATA     = 1'b0;
    localparam logic CMD_RECENTER = 1'b1;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    localparam logic [STATUS_W-1:0] ST_STORED    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_APPLIED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_UNSYNCED  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_RECENTER  = 3'd4;

    typedef enum logic [2:0] {
        PH_HEADER = 3'b001,
        PH_XMOVE  = 3'b010,
        PH_YMOVE  = 3'b100
    } t_phase;

    typedef struct packed {
        logic       cmd;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [CURSOR_W-1:0] cursor_x;
        logic [CURSOR_W-1:0] cursor_y;
        logic [BUTTON_W-1:0] button_bits;
        logic [STATUS_W-1:0] status;
    } t_out_item;

endpackage

[design/mouse_packet_cursor_tracker_unit.sv]
// Throughput: one item per cycle unless the output stalls, which holds the item
// in the input register; the framer and cursor state close their update loop in
// the single compute stage between the input and result registers.
// Reset (i_rst_n low, synchronous) empties both stages, clears the framer,
// cursor and buttons, and loads a 640 by 480 screen size.
module mouse_packet_cursor_tracker_unit #(
    parameter int COORD_BITS = mpct_pkg::COORD_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  mpct_pkg::t_in_item                i_in_item,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output mpct_pkg::t_out_item               o_out_item,
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_idx,
    input  logic [mpct_pkg::SIZE_W-1:0]       i_cfg_data
);
    import mpct_pkg::*;

    localparam int SW = ((COORD_BITS > SIZE_W) ? COORD_BITS : SIZE_W) + 2;
    localparam logic [SW-1:0] COORD_MAX = SW'((64'd1 << COORD_BITS) - 64'd1);

    logic                  r_in_valid;
    t_in_item              r_in_item;
    logic                  r_out_valid;
    t_out_item             r_out_item;
    logic [SIZE_W-1:0]     r_width;
    logic [SIZE_W-1:0]     r_height;
    t_phase                r_phase;
    logic [7:0]            r_hdr;
    logic [7:0]            r_xmove;
    logic [COORD_BITS-1:0] r_pos_x;
    logic [COORD_BITS-1:0] r_pos_y;
    logic [BUTTON_W-1:0]   r_buttons;

    t_phase                n_phase;
    logic [7:0]            n_hdr;
    logic [7:0]            n_xmove;
    logic [COORD_BITS-1:0] n_pos_x;
    logic [COORD_BITS-1:0] n_pos_y;
    logic [BUTTON_W-1:0]   n_buttons;
    logic [STATUS_W-1:0]   n_status;

    logic                  fire;
    logic [SW-1:0]         lim_x;
    logic [SW-1:0]         lim_y;
    logic [SW-1:0]         half_x;
    logic [SW-1:0]         half_y;
    logic signed [SW-1:0]  nx;
    logic signed [SW-1:0]  ny;
    logic [COORD_BITS-1:0] clamp_x;
    logic [COORD_BITS-1:0] clamp_y;

    assign fire        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || fire;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    always_comb begin
        logic [SW-1:0] sx;
        logic [SW-1:0] sy;
        sx = (r_width == '0) ? '0 : SW'(r_width - SIZE_W'(1));
        sy = (r_height == '0) ? '0 : SW'(r_height - SIZE_W'(1));
        lim_x  = (sx > COORD_MAX) ? COORD_MAX : sx;
        lim_y  = (sy > COORD_MAX) ? COORD_MAX : sy;
        half_x = SW'(r_width >> 1);
        half_y = SW'(r_height >> 1);
    end

    always_comb begin
        nx = $signed(SW'(r_pos_x))
            + SW'($signed({(r_hdr & HDR_XSIGN) != '0, r_xmove}));
        ny = $signed(SW'(r_pos_y))
            - SW'($signed({(r_hdr & HDR_YSIGN) != '0, r_in_item.data_byte}));
        if (nx[SW-1]) begin
            clamp_x = '0;
        end else if ($unsigned(nx) > lim_x) begin
            clamp_x = COORD_BITS'(lim_x);
        end else begin
            clamp_x = COORD_BITS'(nx);
        end
        if (ny[SW-1]) begin
            clamp_y = '0;
        end else if ($unsigned(ny) > lim_y) begin
            clamp_y = COORD_BITS'(lim_y);
        end else begin
            clamp_y = COORD_BITS'(ny);
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_hdr     = r_hdr;
        n_xmove   = r_xmove;
        n_pos_x   = r_pos_x;
        n_pos_y   = r_pos_y;
        n_buttons = r_buttons;
        n_status  = ST_STORED;
        if (r_in_item.cmd == CMD_RECENTER) begin
            n_pos_x  = COORD_BITS'((half_x > lim_x) ? lim_x : half_x);
            n_pos_y  = COORD_BITS'((half_y > lim_y) ? lim_y : half_y);
            n_status = ST_RECENTER;
        end else begin
            unique case (r_phase)
                PH_XMOVE: begin
                    n_xmove = r_in_item.data_byte;
                    n_phase = PH_YMOVE;
                end
                PH_YMOVE: begin
                    n_phase = PH_HEADER;
                    if ((r_hdr & HDR_OVERFLOW) != '0) begin
                        n_status = ST_OVERFLOW;
                    end else begin
                        n_pos_x   = clamp_x;
                        n_pos_y   = clamp_y;
                        n_buttons = BUTTON_W'(r_hdr & HDR_BUTTONS);
                        n_status  = ST_APPLIED;
                    end
                end
                default: begin
                    if ((r_in_item.data_byte & HDR_SYNC) != '0) begin
                        n_hdr   = r_in_item.data_byte;
                        n_phase = PH_XMOVE;
                    end else begin
                        n_phase  = PH_HEADER;
                        n_status = ST_UNSYNCED;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_width     <= WIDTH_RESET;
            r_height    <= HEIGHT_RESET;
            r_phase     <= PH_HEADER;
            r_hdr       <= '0;
            r_xmove     <= '0;
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_buttons   <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_WIDTH:  r_width  <= i_cfg_data;
                    CFG_HEIGHT: r_height <= i_cfg_data;
                    default:    r_width  <= r_width;
                endcase
            end
            if (fire) begin
                r_phase   <= n_phase;
                r_hdr     <= n_hdr;
                r_xmove   <= n_xmove;
                r_pos_x   <= n_pos_x;
                r_pos_y   <= n_pos_y;
                r_buttons <= n_buttons;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
        if (fire) begin
            r_out_item.cursor_x    <= CURSOR_W'(n_pos_x);
            r_out_item.cursor_y    <= CURSOR_W'(n_pos_y);
            r_out_item.button_bits <= n_buttons;
            r_out_item.status      <= n_status;
        end
    end

endmodule

[sim/tb_mouse_packet_cursor_tracker_unit.sv]
`timescale 1ns / 100ps

module tb_mouse_packet_cursor_tracker_unit;

    import mpct_pkg::*;

    typedef struct {
        logic       cmd;
        logic [7:0] data;
        bit         typed;
        t_out_item  res;
    } t_dir_row;

    logic                i_clk      = 1'b0;
    logic                i_rst_n    = 1'b0;
    logic                i_in_valid = 1'b0;
    t_in_item            i_in_item  = '0;
    logic                i_out_ready = 1'b0;
    logic                i_cfg_we   = 1'b0;
    logic                i_cfg_idx  = CFG_WIDTH;
    logic [SIZE_W-1:0]   i_cfg_data = '0;
    logic                o_in_ready;
    logic                o_out_valid;
    t_out_item           o_out_item;

    t_out_item           exp_cursor_q [$];
    int                  miss_cnt  = 0;
    int                  stall_left = 0;
    bit                  calm      = 1'b0;

    logic [SIZE_W-1:0]   scr_w = WIDTH_RESET;
    logic [SIZE_W-1:0]   scr_h = HEIGHT_RESET;
    t_phase              trk_phase = PH_HEADER;
    logic [7:0]          hdr_byte  = '0;
    logic [7:0]          move_x    = '0;
    logic [CURSOR_W-1:0] cur_x     = '0;
    logic [CURSOR_W-1:0] cur_y     = '0;
    logic [BUTTON_W-1:0] btn_held  = '0;

    t_dir_row            dir_rows [0:24];

    mouse_packet_cursor_tracker_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int axis_lim(logic [SIZE_W-1:0] sz);
        int lim;
        lim = (sz == 0) ? 0 : int'(sz) - 1;
        if (lim > (1 << COORD_BITS_DEF) - 1) begin
            lim = (1 << COORD_BITS_DEF) - 1;
        end
        return lim;
    endfunction

    function automatic t_out_item track_cursor(t_in_item it);
        t_out_item res;
        int        dx, dy, nx, ny, lx, ly;
        res.status = ST_STORED;
        lx = axis_lim(scr_w);
        ly = axis_lim(scr_h);
        if (it.cmd == CMD_RECENTER) begin
            cur_x = CURSOR_W'((int'(scr_w >> 1) > lx) ? lx : int'(scr_w >> 1));
            cur_y = CURSOR_W'((int'(scr_h >> 1) > ly) ? ly : int'(scr_h >> 1));
            res.status = ST_RECENTER;
        end else if (trk_phase == PH_XMOVE) begin
            move_x    = it.data_byte;
            trk_phase = PH_YMOVE;
        end else if (trk_phase == PH_YMOVE) begin
            trk_phase = PH_HEADER;
            if ((hdr_byte & HDR_OVERFLOW) != 0) begin
                res.status = ST_OVERFLOW;
            end else begin
                dx = int'(move_x) - (((hdr_byte & HDR_XSIGN) != 0) ? 256 : 0);
                dy = int'(it.data_byte) - (((hdr_byte & HDR_YSIGN) != 0) ? 256 : 0);
                nx = int'(cur_x) + dx;
                ny = int'(cur_y) - dy;
                nx = (nx < 0) ? 0 : ((nx > lx) ? lx : nx);
                ny = (ny < 0) ? 0 : ((ny > ly) ? ly : ny);
                cur_x    = CURSOR_W'(nx);
                cur_y    = CURSOR_W'(ny);
                btn_held = BUTTON_W'(hdr_byte & HDR_BUTTONS);
                res.status = ST_APPLIED;
            end
        end else if ((it.data_byte & HDR_SYNC) != 0) begin
            hdr_byte  = it.data_byte;
            trk_phase = PH_XMOVE;
        end else begin
            res.status = ST_UNSYNCED;
        end
        res.cursor_x    = cur_x;
        res.cursor_y    = cur_y;
        res.button_bits = btn_held;
        return res;
    endfunction

    task automatic send_byte(input t_in_item it, input bit typed, input t_out_item typed_res);
        t_out_item pred;
        if (!calm && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pred = track_cursor(it);
        exp_cursor_q.push_back(typed ? typed_res : pred);
    endtask

    task automatic send_data(input logic [7:0] data);
        t_in_item it;
        it.cmd       = CMD_DATA;
        it.data_byte = data;
        send_byte(it, 1'b0, '0);
    endtask

    task automatic send_recenter();
        t_in_item it;
        it.cmd       = CMD_RECENTER;
        it.data_byte = 8'($urandom_range(0, 255));
        send_byte(it, 1'b0, '0);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (exp_cursor_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_screen(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_WIDTH;
        i_cfg_data <= w;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_HEIGHT;
        i_cfg_data <= h;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        scr_w = w;
        scr_h = h;
    endtask

    function automatic logic [SIZE_W-1:0] pick_size();
        case ($urandom_range(0, 3))
            0:       return SIZE_W'($urandom_range(1, 16));
            1:       return SIZE_W'($urandom_range(17, 700));
            2:       return SIZE_W'($urandom_range(700, 4096));
            default: return SIZE_W'($urandom_range(0, 8191));
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_out_item exp_res;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (exp_cursor_q.size() == 0) begin
                miss_cnt++;
                if (miss_cnt <= 10) begin
                    $display("unexpected result x=%0d y=%0d btn=%0d st=%0d",
                             o_out_item.cursor_x, o_out_item.cursor_y,
                             o_out_item.button_bits, o_out_item.status);
                end
            end else begin
                exp_res = exp_cursor_q.pop_front();
                if (o_out_item.cursor_x !== exp_res.cursor_x ||
                    o_out_item.cursor_y !== exp_res.cursor_y ||
                    o_out_item.button_bits !== exp_res.button_bits ||
                    o_out_item.status !== exp_res.status) begin
                    miss_cnt++;
                    if (miss_cnt <= 10) begin
                        $display(
                            "mismatch: exp x=%0d y=%0d btn=%0d st=%0d, got x=%0d y=%0d btn=%0d st=%0d",
                            exp_res.cursor_x, exp_res.cursor_y,
                            exp_res.button_bits, exp_res.status,
                            o_out_item.cursor_x, o_out_item.cursor_y,
                            o_out_item.button_bits, o_out_item.status);
                    end
                end
            end
        end
        if (calm) begin
            i_out_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 9) - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    initial begin
        #3_000_000;
        $display("[mouse_packet_cursor_tracker_unit] ERROR");
        $finish;
    end

    initial begin
        int          sent;
        int          roll;
        logic [7:0]  hdr;
        logic [SIZE_W-1:0] w, h;
        t_in_item    it;

        dir_rows = '{
            '{CMD_RECENTER, 8'hFF, 1'b1, '{12'd320, 12'd240, 3'd0, ST_RECENTER}},
            '{CMD_DATA,     8'h00, 1'b1, '{12'd320, 12'd240, 3'd0, ST_UNSYNCED}},
            '{CMD_DATA,     8'hF7, 1'b1, '{12'd320, 12'd240, 3'd0, ST_UNSYNCED}},
            '{CMD_DATA,     8'h0F, 1'b1, '{12'd320, 12'd240, 3'd0, ST_STORED}},
            '{CMD_DATA,     8'hFF, 1'b1, '{12'd320, 12'd240, 3'd0, ST_STORED}},
            '{CMD_DATA,     8'h80, 1'b0, '0},
            '{CMD_DATA,     8'h3F, 1'b0, '0},
            '{CMD_DATA,     8'h00, 1'b0, '0},
            '{CMD_DATA,     8'h00, 1'b0, '0},
            '{CMD_DATA,     8'hC8, 1'b0, '0},
            '{CMD_DATA,     8'h7F, 1'b0, '0},
            '{CMD_DATA,     8'h7F, 1'b0, '0},
            '{CMD_DATA,     8'h4C, 1'b0, '0},
            '{CMD_RECENTER, 8'h00, 1'b0, '0},
            '{CMD_DATA,     8'h01, 1'b0, '0},
            '{CMD_DATA,     8'h02, 1'b0, '0},
            '{CMD_DATA,     8'h89, 1'b0, '0},
            '{CMD_DATA,     8'h80, 1'b0, '0},
            '{CMD_DATA,     8'h80, 1'b0, '0},
            '{CMD_DATA,     8'h1A, 1'b0, '0},
            '{CMD_DATA,     8'h00, 1'b0, '0},
            '{CMD_DATA,     8'hFF, 1'b0, '0},
            '{CMD_DATA,     8'h18, 1'b0, '0},
            '{CMD_DATA,     8'h00, 1'b0, '0},
            '{CMD_DATA,     8'h00, 1'b0, '0}
        };

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) begin
            it.cmd       = dir_rows[r].cmd;
            it.data_byte = dir_rows[r].data;
            send_byte(it, dir_rows[r].typed, dir_rows[r].res);
        end
        drain();

        for (int ph = 0; ph < 12; ph++) begin
            case (ph)
                0:       begin w = 13'd1;    h = 13'd1;    end
                1:       begin w = 13'd0;    h = 13'd0;    end
                2:       begin w = 13'd4096; h = 13'd4096; end
                3:       begin w = 13'd8191; h = 13'd8191; end
                4:       begin w = 13'd640;  h = 13'd480;  end
                5:       begin w = 13'd1;    h = 13'd4096; end
                default: begin w = pick_size(); h = pick_size(); end
            endcase
            set_screen(w, h);
            if (ph == 11) begin
                calm = 1'b1;
            end
            sent = 0;
            while (sent < 80) begin
                roll = $urandom_range(0, 99);
                if (roll < 75) begin
                    hdr = 8'($urandom_range(0, 255)) | HDR_SYNC;
                    if ($urandom_range(0, 7) != 0) begin
                        hdr = hdr & ~HDR_OVERFLOW;
                    end
                    for (int k = 0; k < 3; k++) begin
                        if ($urandom_range(0, 19) == 0) begin
                            send_recenter();
                            sent++;
                        end
                        send_data((k == 0) ? hdr : 8'($urandom_range(0, 255)));
                        sent++;
                    end
                end else if (roll < 87) begin
                    send_recenter();
                    sent++;
                end else begin
                    send_data(8'($urandom_range(0, 255)));
                    sent++;
                    while (trk_phase != PH_HEADER) begin
                        send_data(8'($urandom_range(0, 255)));
                        sent++;
                    end
                end
            end
            drain();
        end

        repeat (10) @(posedge i_clk);
        if (miss_cnt == 0) begin
            $display("[mouse_packet_cursor_tracker_unit] OK");
        end else begin
            $display("[mouse_packet_cursor_tracker_unit] ERROR");
        end
        $finish;
    end

endmodule
